// File: hw/rtl/scdc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the stopwatch / chaser display block.
// No dependencies.
package scdc_pkg;

    localparam int DIGIT_COUNT_DEF = 8;
    localparam int LED_COUNT_DEF   = 8;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SCAN_PERIOD = 3'd0,
        CFG_SPEED_STEP  = 3'd1,
        CFG_SPEED_MIN   = 3'd2,
        CFG_SPEED_MAX   = 3'd3
    } cfg_idx_t;

    localparam logic [3:0] SCAN_PERIOD_RST = 4'd10;
    localparam logic [5:0] SPEED_STEP_RST  = 6'd5;
    localparam logic [7:0] SPEED_MIN_RST   = 8'd5;
    localparam logic [7:0] SPEED_MAX_RST   = 8'd200;
    localparam logic [7:0] CHASE_DELAY_RST = 8'd50;

    // digit codes
    localparam logic [4:0] CODE_DASH  = 5'd16;
    localparam logic [4:0] CODE_BLANK = 5'd17;

    localparam logic [6:0] CS_LAST  = 7'd99;
    localparam logic [6:0] CS_HALF  = 7'd50;
    localparam logic [6:0] MS_LAST  = 7'd59;

    // classified key presses of one tick
    typedef struct packed {
        logic dir;
        logic slower;
        logic run;
        logic faster;
    } keys_t;

    function automatic logic [7:0] seg_of(input logic [4:0] code);
        logic [7:0] s;
        case (code)
            5'd0:    s = 8'hfc;
            5'd1:    s = 8'h60;
            5'd2:    s = 8'hda;
            5'd3:    s = 8'hf2;
            5'd4:    s = 8'h66;
            5'd5:    s = 8'hb6;
            5'd6:    s = 8'hbe;
            5'd7:    s = 8'he0;
            5'd8:    s = 8'hfe;
            5'd9:    s = 8'hf6;
            5'd10:   s = 8'hee;
            5'd11:   s = 8'h3e;
            5'd12:   s = 8'h9c;
            5'd13:   s = 8'h7a;
            5'd14:   s = 8'h9e;
            5'd15:   s = 8'h8e;
            5'd16:   s = 8'h02;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // tens digit by reciprocal multiply, exact for v < 128
    function automatic logic [4:0] tens_of(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return {1'b0, p[14:11]};
    endfunction

    function automatic logic [4:0] ones_of(input logic [6:0] v);
        logic [14:0] p;
        logic [6:0]  t;
        p = 15'(v) * 15'd205;
        t = 7'(p[14:11]) * 7'd10;
        return 5'(v - t);
    endfunction

endpackage

// File: hw/rtl/stopwatch_chaser_display_ctrl.sv
`timescale 1ns / 1ps
// Top level of the stopwatch / LED chaser / seven-segment display controller.
// Depends on scdc_pkg, scdc_front and scdc_back.
//
// Each input transaction is one 1 ms tick with the sampled key levels; each tick yields
// exactly one result transaction (LED pins, segment byte, digit index, strobe). The block
// takes one tick per clock cycle while the output side keeps up: the front decodes keys
// into a two-entry queue and the back computes a whole tick combinationally into an
// output register. An accepted tick is written into the queue, and m_valid for it rises
// when the back pops it into the output register. When the output side stalls, two
// queued ticks plus the held result fill the block and s_ready drops. Configuration
// registers (index 0 scan period, 1 speed step, 2 speed min, 3 speed max) are written
// with cfg_we and should only be changed while no tick is in flight.
module stopwatch_chaser_display_ctrl import scdc_pkg::*; #(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF,
    parameter int LED_COUNT   = LED_COUNT_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [2:0] cfg_idx,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_key_zero_level,
    input  logic       s_key_one_level,
    input  logic       s_key_two_level,
    input  logic       s_wake_key_level,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_led_drive,
    output logic [7:0] m_segment_pattern,
    output logic [2:0] m_digit_select,
    output logic       m_digit_strobe
);

    logic  q_valid;
    logic  q_pop;
    keys_t q_keys;

    scdc_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_key_zero_level (s_key_zero_level),
        .s_key_one_level  (s_key_one_level),
        .s_key_two_level  (s_key_two_level),
        .s_wake_key_level (s_wake_key_level),
        .q_valid          (q_valid),
        .q_keys           (q_keys),
        .q_pop            (q_pop)
    );

    scdc_back #(
        .DIGIT_COUNT (DIGIT_COUNT),
        .LED_COUNT   (LED_COUNT)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_idx           (cfg_idx),
        .cfg_wdata         (cfg_wdata),
        .q_valid           (q_valid),
        .q_keys            (q_keys),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_led_drive       (m_led_drive),
        .m_segment_pattern (m_segment_pattern),
        .m_digit_select    (m_digit_select),
        .m_digit_strobe    (m_digit_strobe)
    );

endmodule

// File: hw/rtl/scdc_front.sv
`timescale 1ns / 1ps
// Front end: accepts tick transactions, decodes key levels into presses, queues them.
// Depends on scdc_pkg.
module scdc_front import scdc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  logic  s_key_zero_level,
    input  logic  s_key_one_level,
    input  logic  s_key_two_level,
    input  logic  s_wake_key_level,
    output logic  q_valid,
    output keys_t q_keys,
    input  logic  q_pop
);

    keys_t       q_mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    keys_t       keys_in;

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid & s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_keys  = q_mem_reg[rd_ptr_reg];

    // keys 0..2 are active low, wake is active high
    assign keys_in.dir    = ~s_key_zero_level;
    assign keys_in.slower = ~s_key_one_level;
    assign keys_in.run    = ~s_key_two_level;
    assign keys_in.faster = s_wake_key_level;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= keys_in;
        end
    end

endmodule

// File: hw/rtl/scdc_back.sv
`timescale 1ns / 1ps
// Back end: per-tick engine (chaser, stopwatch, key scan, digit mux) and output register.
// Depends on scdc_pkg.
module scdc_back import scdc_pkg::*; #(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF,
    parameter int LED_COUNT   = LED_COUNT_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [2:0] cfg_idx,
    input  logic [7:0] cfg_wdata,
    input  logic       q_valid,
    input  keys_t      q_keys,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_led_drive,
    output logic [7:0] m_segment_pattern,
    output logic [2:0] m_digit_select,
    output logic       m_digit_strobe
);

    localparam logic [3:0] DIG_CNT  = 4'(DIGIT_COUNT);
    localparam logic [3:0] DIG_LAST = 4'(DIGIT_COUNT - 1);
    localparam logic [3:0] LED_CNT  = 4'(LED_COUNT);
    localparam logic [2:0] LED_LAST = 3'(LED_COUNT - 1);

    logic [3:0] scan_period_reg;
    logic [5:0] speed_step_reg;
    logic [7:0] speed_min_reg, speed_max_reg;

    logic [7:0] chase_div_reg, chase_div_next;
    logic [7:0] chase_delay_reg, chase_delay_next;
    logic [2:0] chase_pos_reg, chase_pos_next;
    logic       reverse_reg, reverse_next;
    logic       running_reg, running_next;
    logic [3:0] scan_div_reg, scan_div_next;
    logic [6:0] centi_reg, centi_next;
    logic [5:0] sec_reg, sec_next;
    logic [5:0] min_reg, min_next;
    logic       released_reg, released_next;
    logic [2:0] digit_idx_reg, digit_idx_next;
    logic [4:0] codes_reg [8];
    logic [4:0] codes_next [8];
    logic [7:0] led_reg, led_next;

    logic       m_valid_reg;
    logic [7:0] led_out_reg, seg_out_reg;
    logic [2:0] sel_out_reg;
    logic       strobe_out_reg;

    // tick working values
    logic [8:0] nd;
    logic [4:0] ns;
    logic       chase_fire, scan_fire, strobe;
    logic [6:0] c1, sec_inc, min_inc;
    logic [3:0] pos_inc, idx_inc;
    logic [2:0] led_bit;
    logic [8:0] delay_up;
    logic [7:0] seg;

    assign q_pop   = q_valid & (~m_valid_reg | m_ready);
    assign m_valid = m_valid_reg;
    assign m_led_drive       = led_out_reg;
    assign m_segment_pattern = seg_out_reg;
    assign m_digit_select    = sel_out_reg;
    assign m_digit_strobe    = strobe_out_reg;

    always_comb begin
        chase_div_next   = chase_div_reg;
        chase_delay_next = chase_delay_reg;
        chase_pos_next   = chase_pos_reg;
        reverse_next     = reverse_reg;
        running_next     = running_reg;
        scan_div_next    = scan_div_reg;
        centi_next       = centi_reg;
        sec_next         = sec_reg;
        min_next         = min_reg;
        released_next    = released_reg;
        digit_idx_next   = digit_idx_reg;
        led_next         = led_reg;
        for (int i = 0; i < 8; i++) begin
            codes_next[i] = codes_reg[i];
        end
        c1       = centi_reg;
        sec_inc  = 7'(sec_reg) + 7'd1;
        min_inc  = 7'(min_reg) + 7'd1;
        pos_inc  = 4'(chase_pos_reg) + 4'd1;
        idx_inc  = 4'(digit_idx_reg) + 4'd1;
        led_bit  = 3'd0;
        delay_up = 9'(chase_delay_reg) + 9'(speed_step_reg);
        seg      = 8'h00;
        strobe   = 1'b0;

        nd = 9'(chase_div_reg) + 9'd1;
        ns = 5'(scan_div_reg) + 5'd1;
        chase_fire = (nd > 9'(chase_delay_reg));
        // a zero period compares like one
        scan_fire  = (ns >= 5'(scan_period_reg));

        if (q_pop) begin
            chase_div_next = chase_fire ? 8'd0 : nd[7:0];
            scan_div_next  = scan_fire ? 4'd0 : ns[3:0];

            if (scan_fire) begin
                if (reverse_reg) begin
                    if (running_reg && centi_reg == 7'd0) begin
                        centi_next    = CS_LAST;
                        codes_next[2] = CODE_DASH;
                        codes_next[5] = CODE_DASH;
                        if (sec_reg == 6'd0) begin
                            sec_next = MS_LAST[5:0];
                            min_next = (min_reg == 6'd0) ? MS_LAST[5:0] : min_reg - 6'd1;
                        end else begin
                            sec_next = sec_reg - 6'd1;
                        end
                    end else begin
                        c1 = running_reg ? centi_reg - 7'd1 : centi_reg;
                        centi_next = c1;
                        if (c1 == CS_HALF) begin
                            codes_next[2] = CODE_BLANK;
                            codes_next[5] = CODE_BLANK;
                        end
                    end
                end else begin
                    c1 = running_reg ? centi_reg + 7'd1 : centi_reg;
                    centi_next = c1;
                    if (c1 == CS_HALF) begin
                        codes_next[2] = CODE_BLANK;
                        codes_next[5] = CODE_BLANK;
                    end
                    if (c1 > CS_LAST) begin
                        centi_next    = 7'd0;
                        codes_next[2] = CODE_DASH;
                        codes_next[5] = CODE_DASH;
                        if (sec_inc > MS_LAST) begin
                            sec_next = 6'd0;
                            min_next = (min_inc > MS_LAST) ? 6'd0 : min_inc[5:0];
                        end else begin
                            sec_next = sec_inc[5:0];
                        end
                    end
                end
            end

            if (chase_fire && running_reg) begin
                chase_pos_next = (pos_inc >= LED_CNT) ? 3'd0 : pos_inc[2:0];
                led_bit  = reverse_reg ? chase_pos_next : LED_LAST - chase_pos_next;
                led_next = ~(8'd1 << led_bit);
            end

            // one press per release, priority dir > slower > run > faster
            if (scan_fire) begin
                if (released_reg) begin
                    if (q_keys.dir) begin
                        released_next = 1'b0;
                        reverse_next  = ~reverse_reg;
                    end else if (q_keys.slower) begin
                        released_next = 1'b0;
                        if (chase_delay_reg < speed_max_reg) begin
                            chase_delay_next = delay_up[8] ? 8'hff : delay_up[7:0];
                        end
                    end else if (q_keys.run) begin
                        released_next = 1'b0;
                        running_next  = ~running_reg;
                    end else if (q_keys.faster) begin
                        released_next = 1'b0;
                        if (chase_delay_reg > speed_min_reg) begin
                            chase_delay_next = (chase_delay_reg > 8'(speed_step_reg)) ?
                                chase_delay_reg - 8'(speed_step_reg) : 8'd0;
                        end
                    end
                end else if (!q_keys.dir && !q_keys.slower && !q_keys.run &&
                             !q_keys.faster) begin
                    released_next = 1'b1;
                end
            end

            if (scan_div_next[0]) begin
                strobe = 1'b1;
                digit_idx_next = (idx_inc >= DIG_CNT) ? 3'd0 : idx_inc[2:0];
                seg = seg_of(codes_next[digit_idx_next]);
                if (4'(digit_idx_next) == DIG_LAST) begin
                    codes_next[0] = tens_of(7'(min_next));
                    codes_next[1] = ones_of(7'(min_next));
                    codes_next[3] = tens_of(7'(sec_next));
                    codes_next[4] = ones_of(7'(sec_next));
                    codes_next[6] = tens_of(centi_next);
                    codes_next[7] = ones_of(centi_next);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_period_reg <= SCAN_PERIOD_RST;
            speed_step_reg  <= SPEED_STEP_RST;
            speed_min_reg   <= SPEED_MIN_RST;
            speed_max_reg   <= SPEED_MAX_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_idx))
                CFG_SCAN_PERIOD: scan_period_reg <= cfg_wdata[3:0];
                CFG_SPEED_STEP:  speed_step_reg  <= cfg_wdata[5:0];
                CFG_SPEED_MIN:   speed_min_reg   <= cfg_wdata;
                CFG_SPEED_MAX:   speed_max_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chase_div_reg   <= 8'd0;
            chase_delay_reg <= CHASE_DELAY_RST;
            chase_pos_reg   <= 3'd0;
            reverse_reg     <= 1'b0;
            running_reg     <= 1'b1;
            scan_div_reg    <= 4'd0;
            centi_reg       <= 7'd0;
            sec_reg         <= 6'd0;
            min_reg         <= 6'd0;
            released_reg    <= 1'b1;
            digit_idx_reg   <= 3'd0;
            led_reg         <= 8'hff;
            codes_reg[0]    <= 5'd1;
            codes_reg[1]    <= 5'd2;
            codes_reg[2]    <= CODE_DASH;
            codes_reg[3]    <= 5'd4;
            codes_reg[4]    <= 5'd5;
            codes_reg[5]    <= CODE_DASH;
            codes_reg[6]    <= 5'd7;
            codes_reg[7]    <= 5'd8;
            m_valid_reg     <= 1'b0;
        end else begin
            chase_div_reg   <= chase_div_next;
            chase_delay_reg <= chase_delay_next;
            chase_pos_reg   <= chase_pos_next;
            reverse_reg     <= reverse_next;
            running_reg     <= running_next;
            scan_div_reg    <= scan_div_next;
            centi_reg       <= centi_next;
            sec_reg         <= sec_next;
            min_reg         <= min_next;
            released_reg    <= released_next;
            digit_idx_reg   <= digit_idx_next;
            led_reg         <= led_next;
            for (int i = 0; i < 8; i++) begin
                codes_reg[i] <= codes_next[i];
            end
            if (q_pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            led_out_reg    <= led_next;
            seg_out_reg    <= seg;
            sel_out_reg    <= digit_idx_next;
            strobe_out_reg <= strobe;
        end
    end

endmodule

// File: bench/tb_stopwatch_chaser_display_ctrl.sv
`timescale 1ns / 1ps
// Self-checking bench for stopwatch_chaser_display_ctrl: directed key/display cases, then
// random key sequences under several register settings. Depends on scdc_pkg and the RTL.
module tb_stopwatch_chaser_display_ctrl import scdc_pkg::*;;

    localparam int          STALL_LIMIT   = 4000;
    localparam int          DRAIN_CYCLES  = 6;
    localparam int          HOLD_CYCLES   = 400;
    localparam logic [2:0]  CFG_IDX_SPARE = 3'd6;

    typedef struct packed {
        logic key_zero;
        logic key_one;
        logic key_two;
        logic wake;
    } tick_keys_t;

    typedef struct packed {
        logic [7:0] led;
        logic [7:0] seg;
        logic [2:0] sel;
        logic       strobe;
    } display_out_t;

    localparam tick_keys_t KEYS_IDLE   = '{1'b1, 1'b1, 1'b1, 1'b0};
    localparam tick_keys_t KEYS_DIR    = '{1'b0, 1'b1, 1'b1, 1'b0};
    localparam tick_keys_t KEYS_SLOWER = '{1'b1, 1'b0, 1'b1, 1'b0};
    localparam tick_keys_t KEYS_RUN    = '{1'b1, 1'b1, 1'b0, 1'b0};
    localparam tick_keys_t KEYS_FASTER = '{1'b1, 1'b1, 1'b1, 1'b1};
    localparam tick_keys_t KEYS_ALL    = '{1'b0, 1'b0, 1'b0, 1'b1};

    logic       aclk             = 1'b0;
    logic       aresetn          = 1'b0;
    logic       cfg_we           = 1'b0;
    logic [2:0] cfg_idx          = 3'd0;
    logic [7:0] cfg_wdata        = 8'd0;
    logic       s_valid          = 1'b0;
    logic       s_ready;
    logic       s_key_zero_level = 1'b1;
    logic       s_key_one_level  = 1'b1;
    logic       s_key_two_level  = 1'b1;
    logic       s_wake_key_level = 1'b0;
    logic       m_valid;
    logic       m_ready          = 1'b0;
    logic [7:0] m_led_drive;
    logic [7:0] m_segment_pattern;
    logic [2:0] m_digit_select;
    logic       m_digit_strobe;

    stopwatch_chaser_display_ctrl u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_idx           (cfg_idx),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_key_zero_level  (s_key_zero_level),
        .s_key_one_level   (s_key_one_level),
        .s_key_two_level   (s_key_two_level),
        .s_wake_key_level  (s_wake_key_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_led_drive       (m_led_drive),
        .m_segment_pattern (m_segment_pattern),
        .m_digit_select    (m_digit_select),
        .m_digit_strobe    (m_digit_strobe)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------- predictor state ----------------
    logic [3:0] scan_period_r;
    logic [5:0] speed_step_r;
    logic [7:0] speed_min_r;
    logic [7:0] speed_max_r;

    logic [7:0] chase_div;
    logic [7:0] chase_dly;
    logic [2:0] chase_pos;
    logic       dir_rev;
    logic       sw_running;
    logic [3:0] scan_div;
    logic [6:0] sw_cs;
    logic [5:0] sw_sec;
    logic [5:0] sw_min;
    logic       keys_free;
    logic [2:0] disp_digit;
    logic [4:0] disp_codes [8];
    logic [7:0] led_pins;

    display_out_t pending_displays [$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    bit hold_request   = 1'b0;
    int hold_left      = 0;
    int error_count    = 0;
    int ticks_sent     = 0;
    int results_seen   = 0;
    int settings_count = 0;
    int stall_cycles   = 0;

    function automatic logic [7:0] segment_byte(input logic [4:0] code);
        case (code)
            5'd0:    return 8'hfc;
            5'd1:    return 8'h60;
            5'd2:    return 8'hda;
            5'd3:    return 8'hf2;
            5'd4:    return 8'h66;
            5'd5:    return 8'hb6;
            5'd6:    return 8'hbe;
            5'd7:    return 8'he0;
            5'd8:    return 8'hfe;
            5'd9:    return 8'hf6;
            5'd10:   return 8'hee;
            5'd11:   return 8'h3e;
            5'd12:   return 8'h9c;
            5'd13:   return 8'h7a;
            5'd14:   return 8'h9e;
            5'd15:   return 8'h8e;
            5'd16:   return 8'h02;
            default: return 8'h00;
        endcase
    endfunction

    task automatic reset_predictor();
        scan_period_r = SCAN_PERIOD_RST;
        speed_step_r  = SPEED_STEP_RST;
        speed_min_r   = SPEED_MIN_RST;
        speed_max_r   = SPEED_MAX_RST;
        chase_div     = 8'd0;
        chase_dly     = CHASE_DELAY_RST;
        chase_pos     = 3'd0;
        dir_rev       = 1'b0;
        sw_running    = 1'b1;
        scan_div      = 4'd0;
        sw_cs         = 7'd0;
        sw_sec        = 6'd0;
        sw_min        = 6'd0;
        keys_free     = 1'b1;
        disp_digit    = 3'd0;
        disp_codes    = '{5'd1, 5'd2, CODE_DASH, 5'd4, 5'd5, CODE_DASH, 5'd7, 5'd8};
        led_pins      = 8'hff;
    endtask

    task automatic step_stopwatch();
        logic borrow;
        borrow = 1'b0;
        if (dir_rev) begin
            if (sw_running) begin
                if (sw_cs == 7'd0) borrow = 1'b1;
                else sw_cs = sw_cs - 7'd1;
            end
            if (!borrow && sw_cs == CS_HALF) begin
                disp_codes[2] = CODE_BLANK;
                disp_codes[5] = CODE_BLANK;
            end
            if (borrow) begin
                sw_cs = CS_LAST;
                disp_codes[2] = CODE_DASH;
                disp_codes[5] = CODE_DASH;
                if (sw_sec == 6'd0) begin
                    sw_sec = 6'(MS_LAST);
                    sw_min = (sw_min == 6'd0) ? 6'(MS_LAST) : sw_min - 6'd1;
                end else begin
                    sw_sec = sw_sec - 6'd1;
                end
            end
        end else begin
            if (sw_running) sw_cs = sw_cs + 7'd1;
            if (sw_cs == CS_HALF) begin
                disp_codes[2] = CODE_BLANK;
                disp_codes[5] = CODE_BLANK;
            end
            if (sw_cs > CS_LAST) begin
                sw_cs = 7'd0;
                disp_codes[2] = CODE_DASH;
                disp_codes[5] = CODE_DASH;
                sw_sec = sw_sec + 6'd1;
                if (sw_sec > 6'(MS_LAST)) begin
                    sw_sec = 6'd0;
                    sw_min = sw_min + 6'd1;
                    if (sw_min > 6'(MS_LAST)) sw_min = 6'd0;
                end
            end
        end
    endtask

    task automatic scan_keys(input logic k0, input logic k1, input logic k2, input logic wk);
        logic [8:0] sum;
        if (keys_free) begin
            if (k0) begin
                keys_free = 1'b0;
                dir_rev   = ~dir_rev;
            end else if (k1) begin
                keys_free = 1'b0;
                if (chase_dly < speed_max_r) begin
                    sum = {1'b0, chase_dly} + 9'(speed_step_r);
                    chase_dly = (sum > 9'd255) ? 8'd255 : sum[7:0];
                end
            end else if (k2) begin
                keys_free  = 1'b0;
                sw_running = ~sw_running;
            end else if (wk) begin
                keys_free = 1'b0;
                if (chase_dly > speed_min_r)
                    chase_dly = (chase_dly > 8'(speed_step_r)) ? chase_dly - 8'(speed_step_r)
                                                              : 8'd0;
            end
        end else if (!k0 && !k1 && !k2 && !wk) begin
            keys_free = 1'b1;
        end
    endtask

    task automatic predict_display_tick(input tick_keys_t keys, output display_out_t res);
        logic [8:0] next_div;
        logic [4:0] next_scan;
        logic       chase_fire;
        logic       scan_fire;
        logic [7:0] seg;
        int         pos;
        int         lit;
        next_div   = {1'b0, chase_div} + 9'd1;
        next_scan  = {1'b0, scan_div} + 5'd1;
        chase_fire = next_div > {1'b0, chase_dly};
        chase_div  = chase_fire ? 8'd0 : next_div[7:0];
        scan_fire  = next_scan >= {1'b0, scan_period_r};
        scan_div   = scan_fire ? 4'd0 : next_scan[3:0];

        if (scan_fire) step_stopwatch();

        if (chase_fire && sw_running) begin
            pos = int'(chase_pos) + 1;
            if (pos >= LED_COUNT_DEF) pos = 0;
            chase_pos = 3'(pos);
            lit = dir_rev ? pos : LED_COUNT_DEF - 1 - pos;
            led_pins = ~(8'd1 << lit);
        end

        if (scan_fire) scan_keys(!keys.key_zero, !keys.key_one, !keys.key_two, keys.wake);

        seg = 8'd0;
        if (scan_div[0]) begin
            pos = int'(disp_digit) + 1;
            if (pos >= DIGIT_COUNT_DEF) pos = 0;
            disp_digit = 3'(pos);
            seg = segment_byte(disp_codes[disp_digit]);
            // time digits refresh once the last digit has gone out
            if (pos == DIGIT_COUNT_DEF - 1) begin
                disp_codes[0] = 5'(sw_min / 6'd10);
                disp_codes[1] = 5'(sw_min % 6'd10);
                disp_codes[3] = 5'(sw_sec / 6'd10);
                disp_codes[4] = 5'(sw_sec % 6'd10);
                disp_codes[6] = 5'(sw_cs / 7'd10);
                disp_codes[7] = 5'(sw_cs % 7'd10);
            end
        end
        res = '{led_pins, seg, disp_digit, scan_div[0]};
    endtask

    // ---------------- drivers ----------------
    // all driver tasks start and end just after a falling edge
    task automatic send_tick(input tick_keys_t keys);
        display_out_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_key_zero_level = keys.key_zero;
        s_key_one_level  = keys.key_one;
        s_key_two_level  = keys.key_two;
        s_wake_key_level = keys.wake;
        do @(posedge aclk); while (!s_ready);
        predict_display_tick(keys, res);
        pending_displays.push_back(res);
        ticks_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_for_drain();
        s_valid = 1'b0;
        while (pending_displays.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [7:0] data);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = data;
        case (idx)
            CFG_SCAN_PERIOD: scan_period_r = data[3:0];
            CFG_SPEED_STEP:  speed_step_r  = data[5:0];
            CFG_SPEED_MIN:   speed_min_r   = data;
            CFG_SPEED_MAX:   speed_max_r   = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] period, input logic [7:0] step,
                                  input logic [7:0] lo, input logic [7:0] hi);
        wait_for_drain();
        write_register(CFG_SCAN_PERIOD, period);
        write_register(CFG_SPEED_STEP, step);
        write_register(CFG_SPEED_MIN, lo);
        write_register(CFG_SPEED_MAX, hi);
        write_register(CFG_IDX_SPARE, 8'($urandom));
        settings_count++;
    endtask

    // mostly idle ticks with key presses held across scans, plus some random key noise
    task automatic run_random_ticks(input int count);
        int         press_left;
        tick_keys_t held;
        int         pick;
        press_left = 0;
        held       = KEYS_IDLE;
        for (int i = 0; i < count; i++) begin
            if (press_left == 0 && $urandom_range(99) < 10) begin
                pick = $urandom_range(9);
                case (pick)
                    0, 1:    held = KEYS_DIR;
                    2, 3:    held = KEYS_SLOWER;
                    4, 5:    held = KEYS_RUN;
                    6, 7:    held = KEYS_FASTER;
                    default: held = tick_keys_t'(4'($urandom));
                endcase
                press_left = $urandom_range(2 * int'(scan_period_r) + 3, 1);
            end
            if (press_left > 0) begin
                send_tick(held);
                press_left--;
            end else begin
                send_tick(KEYS_IDLE);
            end
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_reset_state();
        repeat (3) send_tick(KEYS_IDLE);
    endtask

    // scan period zero scans every tick; covers priority, lockout until release and
    // the down-count borrow from 00:00:00 followed by a return to up-counting
    task automatic test_key_priority();
        apply_settings(8'hf0, 8'd50, 8'd1, 8'd255);
        send_tick(KEYS_DIR);
        send_tick(KEYS_IDLE);
        send_tick(KEYS_IDLE);
        send_tick(KEYS_SLOWER);
        send_tick(KEYS_RUN);
        send_tick(KEYS_IDLE);
        send_tick(KEYS_RUN);
        send_tick(KEYS_IDLE);
        send_tick(KEYS_FASTER);
        send_tick(KEYS_IDLE);
        send_tick(KEYS_ALL);
        send_tick(KEYS_IDLE);
        send_tick(KEYS_IDLE);
    endtask

    task automatic test_display_scan();
        apply_settings(8'd2, 8'd1, 8'd255, 8'd1);
        repeat (12) send_tick(KEYS_IDLE);
    endtask

    task automatic test_random_phase(input logic [7:0] period, input logic [7:0] step,
                                     input logic [7:0] lo, input logic [7:0] hi,
                                     input int count);
        apply_settings(period, step, lo, hi);
        run_random_ticks(count);
    endtask

    task automatic test_sender_pause();
        apply_settings(8'd2, 8'hff, 8'd5, 8'd200);
        run_random_ticks(40);
        wait_for_drain();
        run_random_ticks(45);
    endtask

    task automatic test_input_stall();
        hold_request = 1'b1;
        run_random_ticks(80);
    endtask

    // ---------------- result side ----------------
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        display_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_displays.size() == 0) begin
                $error("result transaction with no tick outstanding");
                error_count++;
            end else begin
                want = pending_displays.pop_front();
                results_seen++;
                if (m_led_drive !== want.led) begin
                    $error("led_drive expected %02h got %02h", want.led, m_led_drive);
                    error_count++;
                end
                if (m_segment_pattern !== want.seg) begin
                    $error("segment_pattern expected %02h got %02h", want.seg,
                           m_segment_pattern);
                    error_count++;
                end
                if (m_digit_select !== want.sel) begin
                    $error("digit_select expected %0d got %0d", want.sel, m_digit_select);
                    error_count++;
                end
                if (m_digit_strobe !== want.strobe) begin
                    $error("digit_strobe expected %0d got %0d", want.strobe, m_digit_strobe);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        reset_predictor();
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        send_idle_pct = 22;
        recv_idle_pct = 79;
        test_reset_state();
        test_key_priority();
        test_display_scan();
        test_random_phase(8'd1, 8'd50, 8'd1, 8'd255, 65);
        test_random_phase(8'h0f, 8'd1, 8'd255, 8'd1, 65);

        send_idle_pct = 79;
        recv_idle_pct = 22;
        test_random_phase(8'd3, 8'd20, 8'd100, 8'd150, 65);
        test_sender_pause();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_phase(8'd4, 8'd7, 8'd10, 8'd240, 65);
        test_input_stall();
        test_random_phase(8'h10, 8'd33, 8'd60, 8'd60, 65);

        wait_for_drain();
        $display("%0d ticks sent under %0d register settings, %0d results checked",
                 ticks_sent, settings_count, results_seen);
        if (error_count == 0 && pending_displays.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
